### hdl/srti_pkg.sv
// Shared types and codes for the sorted region table.
`default_nettype none

package srti_pkg;

    localparam int CHROM_W = 8;
    localparam int POS_W   = 32;
    localparam int KEY_W   = CHROM_W + POS_W;
    localparam int SLOT_W  = 8;
    localparam int HELD_W  = 9;
    localparam int STAT_W  = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   start;
        logic [POS_W-1:0]   stop;
    } entry_t;

    // Per-cell control driven by the table controller.
    typedef struct packed {
        logic valid;    // cell holds an entry
        logic is_end;   // cell is the first free slot
        logic is_last;  // cell holds the last entry
        logic wr;       // insert is being applied this cycle
        logic append;   // insert goes to the end of the table
    } cell_ctrl_t;

    // Per-cell status returned to the controller.
    typedef struct packed {
        logic ge;       // stored key not below the new key, or cell empty
        logic take;     // cell loads the new entry
        logic last_gt;  // last entry has a key above the new key
    } cell_stat_t;

endpackage

`default_nettype wire

### hdl/sorted_region_table_insert.sv
// Top level of the sorted region table with insert and read commands.
`default_nettype none

// Sorted region table. Holds up to TABLE_DEPTH regions ordered by
// (chromosome, start). An insert command (s_tuser = 0) places the region
// before the first entry whose key is not less than its own, or appends it
// when its key is at or above the last entry's key; later entries move up
// one slot. A read command (s_tuser = 1) returns the entry at read_index.
// Each item gives one result item: status on m_tuser (0 ok, 1 table full and
// insert dropped, 2 read index at or beyond the count), with slot, entry
// fields and the entry count on m_tdata. The table is a row of cells, one per
// slot; every cell compares its key against the incoming key in parallel and
// either loads the new region, takes its lower neighbor's entry or holds.
// Rate: one item per clock while the result is not stalled; the parallel compare
// across the cell row and the read selection feed the output register directly, and a new item
// is taken whenever the output register is empty or being drained. After
// reset the table is empty; no clearing pass is needed.
module sorted_region_table_insert #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [79:0] s_tdata,  // chromosome[7:0], start_pos[39:8], stop_pos[71:40],
                                  // read_index[79:72]
    input  wire  [0:0]  s_tuser,  // command[0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [95:0] m_tdata,  // slot[7:0], out_chromosome[15:8], out_start[47:16],
                                  // out_stop[79:48], entries_held[88:80], zero[95:89]
    output logic [1:0]  m_tuser   // status[1:0]
);
    import srti_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int EXT_W = (CNT_W > HELD_W) ? CNT_W : HELD_W;

    // Input item fields.
    logic                command;
    entry_t              in_entry;
    logic [SLOT_W-1:0]   read_index;

    assign command        = s_tuser[0];
    assign in_entry.chrom = s_tdata[7:0];
    assign in_entry.start = s_tdata[39:8];
    assign in_entry.stop  = s_tdata[71:40];
    assign read_index     = s_tdata[79:72];

    // Control state.
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                m_tvalid_reg;
    logic                m_tvalid_next;

    // Result registers.
    logic [STAT_W-1:0]   status_reg,  status_next;
    logic [SLOT_W-1:0]   slot_reg,    slot_next;
    entry_t              out_reg,     out_next;
    logic [HELD_W-1:0]   held_reg,    held_next;

    logic                accept;
    logic                full;
    logic                wr;
    logic                append;

    cell_ctrl_t          ctrl  [TABLE_DEPTH];
    cell_stat_t          stat  [TABLE_DEPTH];
    entry_t              cells [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] take_vec;
    logic [TABLE_DEPTH-1:0] last_gt_vec;
    logic [IDX_W-1:0]    ins_idx;

    logic [EXT_W-1:0]    count_ext;
    logic [EXT_W-1:0]    count_next_ext;
    logic [EXT_W-1:0]    ridx_ext;
    logic [EXT_W-1:0]    ins_ext;
    logic                read_ok;

    // Take the next item whenever the result register is free or draining.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = count_reg == CNT_W'(TABLE_DEPTH);
    assign wr       = accept && (command == CMD_INSERT) && !full;
    // Append unless the last entry's key is strictly above the new key.
    assign append   = !(|last_gt_vec);

    // Row of table cells; each hands its entry and compare flag upward.
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        assign ctrl[i].valid   = CNT_W'(i) < count_reg;
        assign ctrl[i].is_end  = CNT_W'(i) == count_reg;
        assign ctrl[i].is_last = CNT_W'(i + 1) == count_reg;
        assign ctrl[i].wr      = wr;
        assign ctrl[i].append  = append;
        assign take_vec[i]     = stat[i].take;
        assign last_gt_vec[i]  = stat[i].last_gt;

        if (i == 0) begin : g_first
            srti_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl[i]),
                .new_entry  (in_entry),
                .prev_entry (in_entry),
                .prev_ge    (1'b0),
                .entry      (cells[i]),
                .stat       (stat[i])
            );
        end else begin : g_rest
            srti_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl[i]),
                .new_entry  (in_entry),
                .prev_entry (cells[i-1]),
                .prev_ge    (stat[i-1].ge),
                .entry      (cells[i]),
                .stat       (stat[i])
            );
        end
    end

    // Encode the one-hot insert position into a slot number.
    always_comb begin
        ins_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (take_vec[i]) begin
                ins_idx = ins_idx | IDX_W'(i);
            end
        end
    end

    assign count_ext      = EXT_W'(count_reg);
    assign count_next_ext = EXT_W'(count_next);
    assign ridx_ext       = EXT_W'(read_index);
    assign ins_ext        = EXT_W'(ins_idx);
    assign read_ok        = ridx_ext < count_ext;

    // Entry count: advance on every stored insert.
    always_comb begin
        count_next = count_reg;
        if (wr) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // Result for the accepted item.
    always_comb begin
        status_next = ST_OK;
        slot_next   = '0;
        out_next    = '0;
        held_next   = count_next_ext[HELD_W-1:0];
        if (command == CMD_INSERT) begin
            if (full) begin
                status_next = ST_FULL;
            end else begin
                slot_next = ins_ext[SLOT_W-1:0];
            end
        end else begin
            if (read_ok) begin
                slot_next = read_index;
                out_next  = cells[ridx_ext[IDX_W-1:0]];
            end else begin
                status_next = ST_RANGE;
            end
        end
    end

    // Output valid: set on accept, drop when taken.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Hold result payload until the next accepted item.
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            out_reg    <= out_next;
            held_reg   <= held_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, held_reg, out_reg.stop, out_reg.start, out_reg.chrom, slot_reg};

    // Count never passes the table depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // A stored insert lands in exactly one cell.
    a_take_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        wr |-> $onehot(take_vec))
        else $error("insert position not one-hot");

    // Nothing is loaded unless an insert is applied.
    a_take_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !wr |-> take_vec == '0)
        else $error("cell loaded without insert");

    // A stored insert raises the count by one.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        wr |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("count did not advance after insert");

    // A stalled result blocks the input side.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

endmodule

`default_nettype wire

### hdl/srti_cell.sv
// One slot of the sorted region table: compare, hold and shift.
`default_nettype none

module srti_cell (
    input  wire                       aclk,
    input  wire srti_pkg::cell_ctrl_t ctrl,
    input  wire srti_pkg::entry_t     new_entry,
    input  wire srti_pkg::entry_t     prev_entry,
    input  wire                       prev_ge,
    output srti_pkg::entry_t          entry,
    output srti_pkg::cell_stat_t      stat
);
    import srti_pkg::*;

    entry_t           entry_reg;
    logic [KEY_W-1:0] own_key;
    logic [KEY_W-1:0] new_key;
    logic             lt;
    logic             gt;
    logic             shift;

    assign own_key = {entry_reg.chrom, entry_reg.start};
    assign new_key = {new_entry.chrom, new_entry.start};
    assign lt      = own_key < new_key;
    assign gt      = own_key > new_key;

    assign stat.ge      = !ctrl.valid || !lt;
    assign stat.last_gt = ctrl.is_last && gt;
    assign stat.take    = ctrl.wr && (ctrl.append ? ctrl.is_end : (stat.ge && !prev_ge));
    // Everything past the insert point moves up one slot.
    assign shift        = ctrl.wr && !ctrl.append && prev_ge;

    always_ff @(posedge aclk) begin
        if (stat.take) begin
            entry_reg <= new_entry;
        end else if (shift) begin
            entry_reg <= prev_entry;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

### test/region_table_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted region table: predicts every result item and compares it.
module region_table_checker #(
    parameter int DEPTH = 256
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    input  wire        s_tready,
    input  wire [79:0] s_tdata,
    input  wire [0:0]  s_tuser,
    input  wire        m_tvalid,
    input  wire        m_tready,
    input  wire [95:0] m_tdata,
    input  wire [1:0]  m_tuser,
    output int         mismatches,
    output int         waiting
);

    typedef struct packed {
        logic [srti_pkg::STAT_W-1:0] status;
        logic [srti_pkg::SLOT_W-1:0] slot;
        srti_pkg::entry_t            region;
        logic [srti_pkg::HELD_W-1:0] held;
    } table_result_t;

    srti_pkg::entry_t regions [DEPTH];
    int unsigned      region_count;
    table_result_t    expected_results [$];
    int               results_seen;

    function automatic logic [srti_pkg::KEY_W-1:0] key_of(srti_pkg::entry_t e);
        return {e.chrom, e.start};
    endfunction

    // Apply one command to the table copy and return the result it gives.
    function automatic table_result_t apply_command(logic cmd, srti_pkg::entry_t item,
                                                    logic [7:0] index);
        table_result_t               r;
        int unsigned                 pos;
        int unsigned                 k;
        logic [srti_pkg::KEY_W-1:0]  key;
        r = '0;
        key = key_of(item);
        if (cmd == srti_pkg::CMD_INSERT) begin
            if (region_count >= DEPTH) begin
                r.status = srti_pkg::ST_FULL;
            end else begin
                if (region_count == 0 || key >= key_of(regions[region_count-1])) begin
                    pos = region_count;
                end else begin
                    pos = 0;
                    while (key_of(regions[pos]) < key) pos++;
                    for (k = region_count; k > pos; k--) regions[k] = regions[k-1];
                end
                regions[pos] = item;
                region_count++;
                r.status = srti_pkg::ST_OK;
                r.slot = srti_pkg::SLOT_W'(pos);
            end
        end else if (index >= region_count) begin
            r.status = srti_pkg::ST_RANGE;
        end else begin
            r.status = srti_pkg::ST_OK;
            r.slot = index;
            r.region = regions[index];
        end
        r.held = srti_pkg::HELD_W'(region_count);
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        table_result_t    want;
        table_result_t    got;
        srti_pkg::entry_t item;
        if (!aresetn) begin
            region_count = 0;
            expected_results.delete();
            mismatches = 0;
            results_seen = 0;
        end else begin
            // Predict on every accepted input item.
            if (s_tvalid && s_tready) begin
                item.chrom = s_tdata[7:0];
                item.start = s_tdata[39:8];
                item.stop  = s_tdata[71:40];
                expected_results.insert(expected_results.size(),
                                        apply_command(s_tuser[0], item, s_tdata[79:72]));
            end
            // Compare every accepted result item against the oldest prediction.
            if (m_tvalid && m_tready) begin
                got.status       = m_tuser;
                got.slot         = m_tdata[7:0];
                got.region.chrom = m_tdata[15:8];
                got.region.start = m_tdata[47:16];
                got.region.stop  = m_tdata[79:48];
                got.held         = m_tdata[88:80];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result %0d arrived with none expected: %p",
                                 $realtime, results_seen, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot ||
                        got.region.chrom !== want.region.chrom ||
                        got.region.start !== want.region.start ||
                        got.region.stop !== want.region.stop || got.held !== want.held) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result %0d mismatch", $realtime, results_seen);
                            $display("  expected status %0d slot %0d chrom %0d start %h stop %h held %0d",
                                     want.status, want.slot, want.region.chrom,
                                     want.region.start, want.region.stop, want.held);
                            $display("  actual   status %0d slot %0d chrom %0d start %h stop %h held %0d",
                                     got.status, got.slot, got.region.chrom,
                                     got.region.start, got.region.stop, got.held);
                        end
                    end
                end
                results_seen++;
            end
        end
        waiting = expected_results.size();
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Top of the sorted region table testbench: clock, reset, stimulus and verdict.
module tb_top;

    import srti_pkg::*;

    localparam int TABLE_DEPTH = 256;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [79:0] s_tdata  = '0;   // chromosome, start_pos, stop_pos, read_index
    logic [0:0]  s_tuser  = '0;   // command
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [95:0] m_tdata;         // slot, out_chromosome, out_start, out_stop, entries_held
    logic [1:0]  m_tuser;         // status

    int mismatches;
    int waiting;

    // Idle bursts on each side are enabled per stretch of the run.
    bit tx_stall_on;
    bit rx_stall_on;

    // Inserts sent so far, used to steer read indexes near the live count.
    int unsigned inserts_sent;

    // Recently inserted keys, replayed to hit equal-key cases.
    logic [KEY_W-1:0] recent_keys [$];

    sorted_region_table_insert #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    region_table_checker #(
        .DEPTH(TABLE_DEPTH)
    ) checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .mismatches(mismatches),
        .waiting   (waiting)
    );

    always #10 aclk = ~aclk;

    // Drop tready in random bursts while stalls are enabled, else hold it high.
    always begin
        @(negedge aclk);
        if (aresetn && rx_stall_on && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        m_tready <= 1'b1;
    end

    // Give up after far more than the slowest correct run could take.
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Offer one item; entered and left at a falling edge. Valid stays high on return
    // so that back-to-back items need no gap.
    task automatic push_item(input logic cmd, input logic [7:0] chrom,
                             input logic [31:0] start, input logic [31:0] stop,
                             input logic [7:0] index);
        if (tx_stall_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {index, stop, start, chrom};
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (cmd == CMD_INSERT) inserts_sent++;
    endtask

    // Hold the sender off until every predicted result has come back.
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (waiting != 0);
    endtask

    // Mix corner keys, small clustered keys, wide random keys and replays.
    function automatic logic [KEY_W-1:0] pick_key();
        logic [7:0]  chrom;
        logic [31:0] start;
        if (recent_keys.size() != 0 && $urandom_range(0, 5) == 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        case ($urandom_range(0, 7))
            0:       chrom = 8'h00;
            1:       chrom = 8'hFF;
            2, 3:    chrom = 8'($urandom_range(0, 3));
            default: chrom = 8'($urandom());
        endcase
        case ($urandom_range(0, 7))
            0:       start = 32'h0;
            1:       start = 32'hFFFF_FFFF;
            2, 3:    start = $urandom_range(0, 255);
            default: start = $urandom();
        endcase
        return {chrom, start};
    endfunction

    task automatic random_item(input int insert_pct);
        logic [KEY_W-1:0] key;
        logic [7:0]       index;
        int unsigned      top;
        if ($urandom_range(0, 99) < insert_pct) begin
            key = pick_key();
            recent_keys.insert(recent_keys.size(), key);
            if (recent_keys.size() > 64) void'(recent_keys.pop_front());
            push_item(CMD_INSERT, key[39:32], key[31:0], $urandom(), 8'($urandom()));
        end else begin
            top = (inserts_sent > 255) ? 255 : inserts_sent;
            index = $urandom_range(0, 1) ? 8'($urandom()) : 8'($urandom_range(0, top));
            push_item(CMD_READ, 8'($urandom()), $urandom(), $urandom(), index);
        end
    endtask

    initial begin
        tx_stall_on  = 1'b0;
        rx_stall_on  = 1'b0;
        inserts_sent = 0;

        // Hold reset, then release it at a falling edge.
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Read an empty table: both ends of the index range are out of range.
        push_item(CMD_READ, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
        push_item(CMD_READ, 8'h00, 32'h0, 32'h0, 8'd255);
        // First insert, then an equal key at the end that must append.
        push_item(CMD_INSERT, 8'd10, 32'd1000, 32'd5, 8'hFF);
        push_item(CMD_INSERT, 8'd10, 32'd1000, 32'd6, 8'h00);
        // Smaller start on the same chromosome shifts the table up.
        push_item(CMD_INSERT, 8'd10, 32'd500, 32'd7, 8'h00);
        push_item(CMD_INSERT, 8'd20, 32'd0, 32'd9, 8'h00);
        // Equal key that is not the last entry goes in front of its twins.
        push_item(CMD_INSERT, 8'd10, 32'd1000, 32'd10, 8'h00);
        // Lowest key lands at the front; highest key appends.
        push_item(CMD_INSERT, 8'h00, 32'h0, 32'h0, 8'h00);
        push_item(CMD_INSERT, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00);
        push_item(CMD_INSERT, 8'hFF, 32'hFFFF_FFFF, 32'h0, 8'h00);
        // Equal to the first entry: goes in front of it.
        push_item(CMD_INSERT, 8'h00, 32'h0, 32'h1, 8'h00);
        // Chromosome outranks start position.
        push_item(CMD_INSERT, 8'd10, 32'hFFFF_FFFF, 32'd3, 8'h00);
        push_item(CMD_INSERT, 8'd11, 32'h0, 32'd4, 8'h00);
        // Walk the whole table, then read the two indexes just past the count.
        for (int i = 0; i <= 12; i++)
            push_item(CMD_READ, 8'($urandom()), $urandom(), $urandom(), 8'(i));
        wait_results_done();

        // Fill the table with random traffic, stalls on or off per stretch.
        for (int i = 0; i < 600; i++) begin
            if (i % 100 == 0) begin
                tx_stall_on = ($urandom_range(0, 3) != 0);
                rx_stall_on = ($urandom_range(0, 3) != 0);
            end
            random_item(50);
        end
        wait_results_done();

        // Full table: inserts drop, reads draw from the whole index range.
        for (int i = 0; i < 250; i++) begin
            if (i % 50 == 0) begin
                tx_stall_on = ($urandom_range(0, 3) != 0);
                rx_stall_on = ($urandom_range(0, 3) != 0);
            end
            random_item(30);
        end

        // Run the last stretch at full rate on both sides.
        tx_stall_on = 1'b0;
        rx_stall_on = 1'b0;
        for (int i = 0; i < 175; i++) random_item(30);

        wait_results_done();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && waiting == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
hdl/srti_pkg.sv
hdl/srti_cell.sv
hdl/sorted_region_table_insert.sv
test/region_table_checker.sv
test/tb_top.sv
